[sv/atpt_pkg.sv]
// shared types, constants and the arctangent table of the point transform
`timescale 1ns / 1ps
`default_nettype none
package atpt_pkg;

  localparam int CordicStages = 24;
  localparam int StageW       = 5;
  localparam int XW           = 44;
  localparam int DW           = 34;
  localparam int CfgIdxW      = 3;

  localparam logic [CfgIdxW-1:0] RegPhiOffset = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOctGain   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOriginX   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOriginY   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOriginZ   = 3'd4;

  // data handed from one vectoring cell to the next
  typedef struct packed {
    logic               vld;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [31:0]        ang;
    logic signed [31:0] z;
  } vec_t;

  // data handed from one rotation cell to the next
  typedef struct packed {
    logic               vld;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [DW-1:0] d;
    logic signed [31:0] z;
  } rot_t;

  // atan(2^-i) in 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [StageW-1:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2F9;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

[sv/atpt_vec_cell.sv]
// one cordic vectoring cell: drives y toward zero and accumulates the angle
`timescale 1ns / 1ps
`default_nettype none
module atpt_vec_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [atpt_pkg::StageW-1:0]  stage_i,
  input  atpt_pkg::vec_t               cell_i,
  output atpt_pkg::vec_t               cell_o
);
  import atpt_pkg::*;

  logic signed [XW-1:0] x_in, y_in, dx, dy;
  vec_t cell_d, cell_q;

  always_comb begin
    x_in   = cell_i.x;
    y_in   = cell_i.y;
    dx     = x_in >>> stage_i;
    dy     = y_in >>> stage_i;
    cell_d = cell_i;
    if (!y_in[XW-1]) begin
      cell_d.x   = x_in + dy;
      cell_d.y   = y_in - dx;
      cell_d.ang = cell_i.ang + atan_turn(stage_i);
    end else begin
      cell_d.x   = x_in - dy;
      cell_d.y   = y_in + dx;
      cell_d.ang = cell_i.ang - atan_turn(stage_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;
endmodule
`default_nettype wire

[sv/atpt_rot_cell.sv]
// one cordic rotation cell: turns (x, y) and drives the residual angle to zero
`timescale 1ns / 1ps
`default_nettype none
module atpt_rot_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [atpt_pkg::StageW-1:0]  stage_i,
  input  atpt_pkg::rot_t               cell_i,
  output atpt_pkg::rot_t               cell_o
);
  import atpt_pkg::*;

  logic signed [XW-1:0] x_in, y_in, dx, dy;
  logic signed [DW-1:0] step;
  rot_t cell_d, cell_q;

  always_comb begin
    x_in   = cell_i.x;
    y_in   = cell_i.y;
    dx     = x_in >>> stage_i;
    dy     = y_in >>> stage_i;
    step   = $signed({2'b00, atan_turn(stage_i)});
    cell_d = cell_i;
    if (!cell_i.d[DW-1]) begin
      cell_d.x = x_in - dy;
      cell_d.y = y_in + dx;
      cell_d.d = cell_i.d - step;
    end else begin
      cell_d.x = x_in + dy;
      cell_d.y = y_in - dx;
      cell_d.d = cell_i.d + step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;
endmodule
`default_nettype wire

[sv/azimuth_twist_point_transform.sv]
// top level: azimuth twist alignment of q16.16 points through two cordic cell rows
//
//  channel | direction | transfer when               | payload
//  --------+-----------+------------------------------+------------------------------
//  point   | in        | start_i & !busy_o            | in_x_i, in_y_i, in_z_i
//  result  | out       | out_valid_o (one cycle)      | out_x_o, out_y_o, out_z_o
//  config  | in        | cfg_valid_i & cfg_ready_o    | cfg_index_i, cfg_data_i
//
// one point per clock, through two rows of cordic cells, a scale/twist multiply stage,
// an azimuth stage and the output saturation stage
// busy_o stays low: the pipeline never stops, and the receiver cannot stall
// reset clears the valid bits of every stage and the configuration registers
// configuration is taken every cycle and applies to points in flight
`timescale 1ns / 1ps
`default_nettype none
module azimuth_twist_point_transform (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [31:0]            in_x_i,
  input  logic signed [31:0]            in_y_i,
  input  logic signed [31:0]            in_z_i,
  output logic                          out_valid_o,
  output logic signed [31:0]            out_x_o,
  output logic signed [31:0]            out_y_o,
  output logic signed [31:0]            out_z_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [atpt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import atpt_pkg::*;

  localparam logic [30:0] InvGainSq = 31'd1583795510;

  // saturate a 38-bit sum to 32 bits
  function automatic logic [31:0] sat32(input logic signed [37:0] v);
    logic [31:0] r;
    if (v[37:31] == 7'h00 || v[37:31] == 7'h7F) r = v[31:0];
    else if (v[37]) r = 32'h80000000;
    else r = 32'h7FFFFFFF;
    return r;
  endfunction

  // configuration registers
  logic [23:0]        phi_q;
  logic signed [23:0] gain_q;
  logic signed [31:0] org_x_q, org_y_q, org_z_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phi_q   <= '0;
      gain_q  <= '0;
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegPhiOffset: phi_q   <= cfg_data_i[23:0];
        RegOctGain:   gain_q  <= cfg_data_i[23:0];
        RegOriginX:   org_x_q <= cfg_data_i;
        RegOriginY:   org_y_q <= cfg_data_i;
        RegOriginZ:   org_z_q <= cfg_data_i;
        default: ;  // index beyond the register list is dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- vectoring row
  vec_t vec_pipe [CordicStages+1];
  logic signed [XW-1:0] in_xs, in_ys;

  always_comb begin
    in_xs = {{4{in_x_i[31]}}, in_x_i, 8'h00};  // 8 guard bits
    in_ys = {{4{in_y_i[31]}}, in_y_i, 8'h00};
    vec_pipe[0].vld = start_i && !busy_o;
    vec_pipe[0].z   = in_z_i;
    if (in_xs[XW-1]) begin
      // left half plane: turn by half a turn first
      vec_pipe[0].x   = -in_xs;
      vec_pipe[0].y   = -in_ys;
      vec_pipe[0].ang = 32'h80000000;
    end else begin
      vec_pipe[0].x   = in_xs;
      vec_pipe[0].y   = in_ys;
      vec_pipe[0].ang = 32'h0;
    end
  end

  for (genvar g = 0; g < CordicStages; g++) begin : g_vec
    atpt_vec_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (StageW'(g)),
      .cell_i  (vec_pipe[g]),
      .cell_o  (vec_pipe[g+1])
    );
  end

  // ---------------------------------------------------------------- multiply stage
  // radius scaled by 1/K^2 in two partial products, twist product
  vec_t                 vec_last;
  logic [25:0]          mag_hi;
  logic [15:0]          mag_lo;
  logic [23:0]          az_d;
  logic [20:0]          pos;
  logic                 p1_vld_q;
  logic [56:0]          p1_hi_q;
  logic [46:0]          p1_lo_q;
  logic [23:0]          p1_az_q;
  logic signed [45:0]   p1_tw_q;
  logic signed [31:0]   p1_z_q;
  logic [31:0]          ang_rnd;

  assign vec_last = vec_pipe[CordicStages];
  assign mag_hi   = vec_last.x[41:16];
  assign mag_lo   = vec_last.x[15:0];
  assign ang_rnd  = vec_last.ang + 32'd128;
  assign az_d     = ang_rnd[31:8];
  assign pos      = az_d[20:0];  // a half turn only touches bit 23, octant position unchanged

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= vec_last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_hi_q <= 57'(mag_hi) * 57'(InvGainSq);
    p1_lo_q <= 47'(mag_lo) * 47'(InvGainSq);
    p1_az_q <= az_d;
    p1_tw_q <= 46'(gain_q) * $signed({25'h0, pos});
    p1_z_q  <= vec_last.z;
  end

  // ---------------------------------------------------------------- azimuth stage
  logic [57:0]        r_sum;
  logic signed [45:0] tw_sum;
  logic               p2_vld_q;
  logic [41:0]        p2_r_q;
  logic [23:0]        p2_naz_q;
  logic signed [31:0] p2_z_q;

  assign r_sum  = 58'(p1_hi_q) + 58'(p1_lo_q[46:16]);
  assign tw_sum = p1_tw_q + 46'sd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
    end else begin
      p2_vld_q <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_r_q   <= r_sum[57:16];
    p2_naz_q <= p1_az_q + phi_q + tw_sum[39:16];
    p2_z_q   <= p1_z_q;
  end

  // ---------------------------------------------------------------- rotation row
  rot_t rot_pipe [CordicStages+1];
  logic signed [DW-1:0] d0;
  logic signed [XW-1:0] r_ext;

  always_comb begin
    d0    = DW'($signed({p2_naz_q, 8'h00}));
    r_ext = $signed({2'b00, p2_r_q});
    rot_pipe[0].vld = p2_vld_q;
    rot_pipe[0].y   = '0;
    rot_pipe[0].z   = p2_z_q;
    // target beyond a quarter turn: start from the negated radius
    if (d0 > 34'sh040000000) begin
      rot_pipe[0].d = d0 - 34'sh080000000;
      rot_pipe[0].x = -r_ext;
    end else if (d0 < -34'sh040000000) begin
      rot_pipe[0].d = d0 + 34'sh080000000;
      rot_pipe[0].x = -r_ext;
    end else begin
      rot_pipe[0].d = d0;
      rot_pipe[0].x = r_ext;
    end
  end

  for (genvar g = 0; g < CordicStages; g++) begin : g_rot
    atpt_rot_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (StageW'(g)),
      .cell_i  (rot_pipe[g]),
      .cell_o  (rot_pipe[g+1])
    );
  end

  // ---------------------------------------------------------------- output stage
  rot_t                 rot_last;
  logic signed [XW-1:0] rx_rnd, ry_rnd;
  logic signed [37:0]   sx, sy, sz;

  assign rot_last = rot_pipe[CordicStages];
  assign rx_rnd   = (rot_last.x + 44'sd128) >>> 8;  // drop guard bits, round half up
  assign ry_rnd   = (rot_last.y + 44'sd128) >>> 8;
  assign sx       = 38'(rx_rnd) + 38'(org_x_q);
  assign sy       = 38'(ry_rnd) + 38'(org_y_q);
  assign sz       = 38'(rot_last.z) + 38'(org_z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= rot_last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_o <= sat32(sx);
    out_y_o <= sat32(sy);
    out_z_o <= sat32(sz);
  end

  // ---------------------------------------------------------------- checks
  logic signed [DW-1:0] d_bound;
  assign d_bound = $signed({2'b00, atan_turn(StageW'(CordicStages - 1))}) * 34'sd2 + 34'sd64;

  // vectoring leaves a non-negative radius
  a_vec_radius_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vec_last.vld |-> !vec_last.x[XW-1])
    else $error("vectoring radius negative");

  // rotation has converged on the target angle
  a_rot_converged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot_last.vld |-> (rot_last.d <= d_bound) && (rot_last.d >= -d_bound))
    else $error("rotation residual angle too large");

  // a point leaving the vectoring row reaches the rotation row through the multiply and azimuth registers
  a_mid_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vec_last.vld |-> ##2 rot_pipe[0].vld)
    else $error("point lost between cordic rows");

endmodule
`default_nettype wire

[dv/atpt_checker.sv]
// result checker for the point transform: models each point and compares the outputs
`timescale 1ns / 1ps
`default_nettype none
module atpt_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic signed [31:0]           in_x_i,
  input  logic signed [31:0]           in_y_i,
  input  logic signed [31:0]           in_z_i,
  input  logic                         out_valid_i,
  input  logic signed [31:0]           out_x_i,
  input  logic signed [31:0]           out_y_i,
  input  logic signed [31:0]           out_z_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [atpt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  output int                           err_cnt_o,
  output int                           pending_o,
  output int                           seen_o
);
  import atpt_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  localparam logic [31:0] InvGainSq = 32'd1583795510;

  logic [31:0] atan_rom [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  logic [23:0]        phi_q  = '0;
  logic signed [23:0] gain_q = '0;
  logic signed [31:0] org_x_q = '0;
  logic signed [31:0] org_y_q = '0;
  logic signed [31:0] org_z_q = '0;

  point_t aligned_q[$];
  int     errors = 0;
  int     seen = 0;

  assign err_cnt_o = errors;
  assign pending_o = aligned_q.size();
  assign seen_o    = seen;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // vectoring, twist of the azimuth, rotation back at the same radius
  function automatic point_t align_point(input point_t p);
    longint      x, y, dx, dy, r, rx, ry, d, tw;
    logic [31:0] ang, rnd, t;
    logic [63:0] mag;
    logic [23:0] az, sh, naz;
    logic [20:0] pos;
    logic signed [31:0] ts;
    point_t      o;
    x = longint'(p.x) * 256;
    y = longint'(p.y) * 256;
    ang = '0;
    // left half plane: flip by a half turn first
    if (x < 0) begin
      x = -x; y = -y; ang = 32'h80000000;
    end
    for (int i = 0; i < CordicStages && i < 32; i++) begin
      dx = x >>> i; dy = y >>> i;
      if (y >= 0) begin
        x += dy; y -= dx; ang += atan_rom[i];
      end else begin
        x -= dy; y += dx; ang -= atan_rom[i];
      end
    end
    // remove the gain of both passes at once
    mag = x;
    r = longint'(((mag >> 16) * InvGainSq + (((mag & 64'hFFFF) * InvGainSq) >> 16)) >> 16);
    rnd = ang + 32'd128;
    az  = rnd[31:8];
    sh  = az + 24'h800000;
    pos = sh[20:0];
    tw  = (longint'(gain_q) * longint'({43'd0, pos}) + 32768) >>> 16;
    naz = az + phi_q + tw[23:0];
    t   = {naz, 8'h00};
    ts  = t;
    d   = ts;
    rx  = r; ry = 0;
    // targets past a quarter turn start from the negated radius
    if (d > 64'sd1073741824) begin
      d -= 64'sd2147483648; rx = -rx;
    end else if (d < -64'sd1073741824) begin
      d += 64'sd2147483648; rx = -rx;
    end
    for (int i = 0; i < CordicStages && i < 32; i++) begin
      dx = rx >>> i; dy = ry >>> i;
      if (d >= 0) begin
        rx -= dy; ry += dx; d -= longint'(atan_rom[i]);
      end else begin
        rx += dy; ry -= dx; d += longint'(atan_rom[i]);
      end
    end
    o.x = clamp32(((rx + 128) >>> 8) + longint'(org_x_q));
    o.y = clamp32(((ry + 128) >>> 8) + longint'(org_y_q));
    o.z = clamp32(longint'(p.z) + longint'(org_z_q));
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    point_t p, e;
    if (rst_ni) begin
      if (out_valid_i) begin
        seen++;
        if (aligned_q.size() == 0) begin
          report_mismatch("unexpected result x", out_x_i, '0);
        end else begin
          e = aligned_q.pop_front();
          if (out_x_i !== e.x) report_mismatch("out_x", out_x_i, e.x);
          if (out_y_i !== e.y) report_mismatch("out_y", out_y_i, e.y);
          if (out_z_i !== e.z) report_mismatch("out_z", out_z_i, e.z);
        end
      end
      if (start_i && !busy_i) begin
        p.x = in_x_i; p.y = in_y_i; p.z = in_z_i;
        aligned_q.push_back(align_point(p));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegPhiOffset: phi_q   <= cfg_data_i[23:0];
          RegOctGain:   gain_q  <= cfg_data_i[23:0];
          RegOriginX:   org_x_q <= cfg_data_i;
          RegOriginY:   org_y_q <= cfg_data_i;
          RegOriginZ:   org_z_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

[dv/tb.sv]
// testbench top: point stimulus, register settings and the final verdict
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import atpt_pkg::*;

  // pipeline depth plus margin, used before register writes and at the end
  localparam int DrainCycles = 2 * CordicStages + 3 + 10;
  localparam int PhaseItems  = 310;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic signed [31:0]  in_x_i = '0;
  logic signed [31:0]  in_y_i = '0;
  logic signed [31:0]  in_z_i = '0;
  logic                out_valid_o;
  logic signed [31:0]  out_x_o, out_y_o, out_z_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [31:0]         cfg_data_i = '0;

  int err_cnt, pending, seen;
  int points_sent = 0;
  int reg_writes = 0;
  int idle_pct = 0;

  azimuth_twist_point_transform u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_x_i, .in_y_i, .in_z_i,
    .out_valid_o, .out_x_o, .out_y_o, .out_z_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  atpt_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .in_x_i, .in_y_i, .in_z_i,
    .out_valid_i(out_valid_o), .out_x_i(out_x_o), .out_y_i(out_y_o), .out_z_i(out_z_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .err_cnt_o(err_cnt), .pending_o(pending), .seen_o(seen)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

  // one point transfer, optionally after a few idle cycles
  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_x_i  <= x;
    in_y_i  <= y;
    in_z_i  <= z;
    do @(posedge clk_i); while (busy_o);
    points_sent++;
  endtask

  // let the pipeline empty so a register write cannot hit points in flight
  task automatic drain;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_writes++;
  endtask

  task automatic set_regs(input logic [23:0] phi, input logic [23:0] gain,
                          input logic [31:0] ox, input logic [31:0] oy,
                          input logic [31:0] oz);
    write_reg(RegPhiOffset, {8'd0, phi});
    write_reg(RegOctGain, {{8{gain[23]}}, gain});
    write_reg(RegOriginX, ox);
    write_reg(RegOriginY, oy);
    write_reg(RegOriginZ, oz);
  endtask

  // mostly full-range points, some small, some on the axes or the z axis
  function automatic logic [31:0] rand_coord(input int mode);
    logic [31:0] v;
    case (mode)
      0: v = $urandom;
      1: v = $signed($urandom_range(2097152)) - 32'sd1048576;
      2: v = '0;
      default: v = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
    endcase
    return v;
  endfunction

  task automatic random_points(input int n);
    int mx, my;
    for (int i = 0; i < n; i++) begin
      mx = ($urandom_range(9) < 6) ? 0 : $urandom_range(3);
      my = ($urandom_range(9) < 6) ? 0 : $urandom_range(3);
      send_point(rand_coord(mx), rand_coord(my), rand_coord($urandom_range(1)));
    end
  endtask

  function automatic logic [31:0] rand_origin;
    case ($urandom_range(3))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $signed($urandom_range(131072)) - 32'sd65536;
    endcase
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset settings, then extremes and the special quadrants
    send_point(32'h0, 32'h0, 32'h0);                  // origin, zero radius
    send_point(32'h0, 32'h0, 32'h7FFFFFFF);           // z axis, z extreme
    send_point(32'h0, 32'h0, 32'h80000000);
    send_point(32'h00010000, 32'h0, 32'h00010000);    // positive x axis
    send_point(32'hFFFF0000, 32'h0, 32'h0);           // negative x axis, left half plane
    send_point(32'h0, 32'h00010000, 32'h0);           // +y
    send_point(32'h0, 32'hFFFF0000, 32'h0);           // -y
    send_point(32'hFFFF0000, 32'h00008000, 32'h0);    // second quadrant
    send_point(32'hFFFF0000, 32'hFFFF8000, 32'h0);    // third quadrant
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF); // largest radius
    send_point(32'h80000000, 32'h80000000, 32'h0);
    send_point(32'h80000000, 32'h7FFFFFFF, 32'h0);
    send_point(32'h7FFFFFFF, 32'h80000000, 32'h0);
    send_point(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0);
    drain();

    // half-turn offset with peak twist: targets beyond a quarter turn
    set_regs(24'h800000, 24'h7FFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    // spare register indexes must be ignored
    for (int k = 1; k <= 3; k++) write_reg(RegOriginZ + k[CfgIdxW-1:0], $urandom);
    send_point(32'h0, 32'h0, 32'h7FFFFFFF);           // z axis with origins, saturation
    send_point(32'h00010000, 32'h00010000, 32'h80000000);
    send_point(32'hFFFF0000, 32'h00010000, 32'h0);
    send_point(32'h7FFFFFFF, 32'h0, 32'h00000001);
    send_point(32'h0, 32'h80000000, 32'h0);
    drain();
    set_regs(24'hFFFFFF, 24'h800000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_point(32'h00010000, 32'h00000100, 32'h80000000);
    send_point(32'hFFFF0000, 32'hFFFFFF00, 32'h0);
    send_point(32'h80000000, 32'h0, 32'hFFFFFFFF);
    send_point(32'h0, 32'h0, 32'h0);

    // three random phases: light, heavy and no sender idling
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 6 : (ph == 1) ? 79 : 0;
      for (int seg = 0; seg < 3; seg++) begin
        drain();
        if (ph == 2 && seg == 0)
          set_regs('0, '0, '0, '0, '0);
        else
          set_regs(24'($urandom), 24'($urandom), rand_origin(), rand_origin(),
                   rand_origin());
        random_points(PhaseItems / 3);
      end
    end

    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d points sent, %0d results checked, %0d register writes",
             points_sent, seen, reg_writes);
    $display("covered axes, quadrants, saturation and three sender idle profiles");
    if (err_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
